/* src/vpa_pkg.sv */
// shared types, constants and codes of the variable partition allocator
package vpa_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ARENA_BYTES   = 4096;
    localparam int ADDR_W        = 32;
    localparam int LEN_W         = ADDR_W + 1;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam logic [ADDR_W-1:0] ADDR_MASK  = {ADDR_W{1'b1}};
    localparam logic [ADDR_W-1:0] ARENA_SIZE = ADDR_W'(ARENA_BYTES);

    // opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // placement rules
    localparam logic [1:0] FIT_BEST  = 2'd0;
    localparam logic [1:0] FIT_FIRST = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_ALREADY = 3'd4;
    localparam logic [2:0] ST_SPACE   = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] req_size;
        logic [1:0]  fit_policy;
        logic [31:0] free_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] block_address;
        logic [31:0] block_size;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic              is_free;
    } entry_t;

    // control from the sequencer to the fit unit
    typedef struct packed {
        logic              clear;
        logic              find_addr;
        logic [1:0]        policy;
        logic [31:0]       size;
        logic [ADDR_W-1:0] addr;
    } fit_ctl_t;

    // selection held by the fit unit
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        entry_t           sel;
        entry_t           prev;
    } fit_res_t;

endpackage

/* src/vpa_fit.sv */
// compare unit that picks a block by fit rule or finds a block by its base
module vpa_fit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vpa_pkg::fit_ctl_t           ctl,
    input  logic                        ent_valid,
    input  logic [vpa_pkg::IDX_W-1:0]   ent_idx,
    input  vpa_pkg::entry_t             ent,
    output vpa_pkg::fit_res_t           res
);

    logic              found_reg;
    logic [vpa_pkg::IDX_W-1:0] idx_reg;
    vpa_pkg::entry_t   sel_reg;
    vpa_pkg::entry_t   prev_reg;
    vpa_pkg::entry_t   last_reg;
    logic              qual;
    logic              better;
    logic              take;

    // does this entry qualify, and does it beat the current pick
    always_comb
    begin
        if (ctl.find_addr)
        begin
            qual = (ent.base == ctl.addr);
        end
        else
        begin
            qual = ent.is_free && (ent.len >= {1'b0, ctl.size});
        end
        if (!found_reg)
        begin
            better = 1'b1;
        end
        else if (ctl.find_addr || ctl.policy == vpa_pkg::FIT_FIRST)
        begin
            better = 1'b0;
        end
        else if (ctl.policy == vpa_pkg::FIT_WORST)
        begin
            better = ent.len > sel_reg.len;
        end
        else
        begin
            better = ent.len < sel_reg.len;
        end
        take = ent_valid && qual && better;
    end

    // selection registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            idx_reg  <= ent_idx;
            sel_reg  <= ent;
            prev_reg <= last_reg;
        end
        if (ent_valid)
        begin
            last_reg <= ent;
        end
    end

    assign res.found = found_reg;
    assign res.idx   = idx_reg;
    assign res.sel   = sel_reg;
    assign res.prev  = prev_reg;

endmodule

/* src/variable_partition_allocator_unit.sv */
// top level: block table, sequencer and response register of the allocator
//
//  channel | signals                         | carries
//  --------+---------------------------------+--------------------------------
//  request | req_valid, req_ready, req_data  | opcode, size, policy, address
//  result  | rsp_valid, rsp_ready, rsp_data  | status, block address and size
//
// A request scans the table through the single table read port, and a split or
// a merge then shifts the entries behind the changed block. Reset leaves one
// free arena at base 0; no clearing pass is needed. req_ready is high only while
// the sequencer is idle; a waiting result sits in its own register and does not
// stop a new request from being taken, but the next result waits until it is taken.
module variable_partition_allocator_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  vpa_pkg::req_t   req_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output vpa_pkg::rsp_t   rsp_data
);

    localparam int IW = vpa_pkg::IDX_W;
    localparam int CW = vpa_pkg::CNT_W;
    localparam int AW = vpa_pkg::ADDR_W;
    localparam int LW = vpa_pkg::LEN_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_NXT    = 4'd4;
    localparam logic [3:0] S_MERGE  = 4'd5;
    localparam logic [3:0] S_SHIFT  = 4'd6;
    localparam logic [3:0] S_FIN_A  = 4'd7;
    localparam logic [3:0] S_FIN_B  = 4'd8;
    localparam logic [3:0] S_RESP   = 4'd9;

    localparam logic [CW-1:0] CNT_MAX = CW'(vpa_pkg::TABLE_ENTRIES);

    // block table
    vpa_pkg::entry_t mem [vpa_pkg::TABLE_ENTRIES];

    logic [3:0]          state_reg, state_next;
    vpa_pkg::req_t       req_reg, req_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       next_base_reg, next_base_next;
    logic                top_reg, top_next;
    logic                e0_init_reg, e0_init_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       left_reg, left_next;
    logic                up_reg, up_next;
    logic [1:0]          k_reg, k_next;
    logic                v_reg;
    logic [IW-1:0]       vidx_reg;
    logic                rd_init_reg;
    vpa_pkg::entry_t     rd_data_reg;
    logic [LW-1:0]       len_reg, len_next;
    logic                nf_reg, nf_next;
    logic                has_next_reg, has_next_next;
    logic [IW-1:0]       a_addr_reg, a_addr_next;
    vpa_pkg::entry_t     a_data_reg, a_data_next;
    logic                b_en_reg, b_en_next;
    logic [IW-1:0]       b_addr_reg, b_addr_next;
    vpa_pkg::entry_t     b_data_reg, b_data_next;
    vpa_pkg::rsp_t       res_reg, res_next;
    vpa_pkg::rsp_t       rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    vpa_pkg::entry_t     wr_data;
    vpa_pkg::entry_t     rd_eff;
    vpa_pkg::entry_t     reset_entry;

    vpa_pkg::fit_ctl_t   fit_ctl;
    vpa_pkg::fit_res_t   fit_res;

    logic [AW-1:0]       sp_n;
    logic [AW-1:0]       sp_diff;
    logic                sp_fit;
    logic                sp_hit_top;
    logic                is_large;
    logic                pf;
    logic [IW-1:0]       mp;
    logic [AW-1:0]       m_base;
    logic [LW-1:0]       m_len;
    logic [CW-1:0]       m_first;

    assign reset_entry = '{base: '0, len: LW'(vpa_pkg::ARENA_BYTES), is_free: 1'b1};
    assign rd_eff      = rd_init_reg ? reset_entry : rd_data_reg;

    // table memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // fit and lookup unit
    assign fit_ctl.clear     = (state_reg == S_START);
    assign fit_ctl.find_addr = (req_reg.opcode == vpa_pkg::OP_FREE);
    assign fit_ctl.policy    = req_reg.fit_policy;
    assign fit_ctl.size      = req_reg.req_size;
    assign fit_ctl.addr      = req_reg.free_address;

    vpa_fit u_fit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fit_ctl),
        .ent_valid (v_reg && state_reg == S_SCAN),
        .ent_idx   (vidx_reg),
        .ent       (rd_eff),
        .res       (fit_res)
    );

    // space check against the top of the address space
    assign is_large   = req_reg.req_size >= vpa_pkg::ARENA_SIZE;
    assign sp_n       = is_large ? req_reg.req_size : vpa_pkg::ARENA_SIZE;
    assign sp_diff    = vpa_pkg::ADDR_MASK - next_base_reg;
    assign sp_fit     = !top_reg && ((sp_n - AW'(1)) <= sp_diff);
    assign sp_hit_top = ((sp_n - AW'(1)) == sp_diff);

    // merge with predecessor
    assign pf      = (fit_res.idx != '0) && fit_res.prev.is_free;
    assign mp      = pf ? fit_res.idx - IW'(1) : fit_res.idx;
    assign m_base  = pf ? fit_res.prev.base : fit_res.sel.base;
    assign m_len   = pf ? fit_res.prev.len + len_reg : len_reg;
    assign m_first = {1'b0, mp} + CW'(1) + CW'(k_next);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        next_base_next = next_base_reg;
        top_next       = top_reg;
        e0_init_next   = e0_init_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        up_next        = up_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        nf_next        = nf_reg;
        has_next_next  = has_next_reg;
        a_addr_next    = a_addr_reg;
        a_data_next    = a_data_reg;
        b_en_next      = b_en_reg;
        b_addr_next    = b_addr_reg;
        b_data_next    = b_data_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = a_addr_reg;
        wr_data        = a_data_reg;
        req_ready      = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_data;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                res_next  = '{status: vpa_pkg::ST_OK, block_address: '0, block_size: '0};
                ptr_next  = '0;
                b_en_next = 1'b0;
                unique case (req_reg.opcode)
                    vpa_pkg::OP_ALLOC:
                    begin
                        if (req_reg.req_size == '0)
                        begin
                            res_next.status = vpa_pkg::ST_ZERO;
                            state_next      = S_RESP;
                        end
                        else if (is_large)
                        begin
                            if (count_reg == CNT_MAX)
                            begin
                                res_next.status = vpa_pkg::ST_FULL;
                                state_next      = S_RESP;
                            end
                            else if (!sp_fit)
                            begin
                                res_next.status = vpa_pkg::ST_SPACE;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                if (sp_hit_top)
                                begin
                                    top_next = 1'b1;
                                end
                                else
                                begin
                                    next_base_next = next_base_reg + sp_n;
                                end
                                a_addr_next = count_reg[IW-1:0];
                                a_data_next = '{base: next_base_reg,
                                                len: {1'b0, req_reg.req_size},
                                                is_free: 1'b0};
                                count_next  = count_reg + CW'(1);
                                res_next.block_address = next_base_reg;
                                res_next.block_size    = req_reg.req_size;
                                state_next  = S_FIN_A;
                            end
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    vpa_pkg::OP_FREE:
                    begin
                        state_next = S_SCAN;
                    end
                    vpa_pkg::OP_CLEAR:
                    begin
                        count_next     = CW'(1);
                        next_base_next = vpa_pkg::ARENA_SIZE;
                        top_next       = 1'b0;
                        e0_init_next   = 1'b1;
                        state_next     = S_RESP;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_SCAN:
            begin
                rd_en = (ptr_reg < count_reg);
                if (rd_en)
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
                else if (!v_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (req_reg.opcode == vpa_pkg::OP_FREE)
                begin
                    if (!fit_res.found)
                    begin
                        res_next.status = vpa_pkg::ST_UNKNOWN;
                        state_next      = S_RESP;
                    end
                    else if (fit_res.sel.is_free)
                    begin
                        res_next.status = vpa_pkg::ST_ALREADY;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        has_next_next = ({1'b0, fit_res.idx} + CW'(1)) < count_reg;
                        rd_en         = has_next_next;
                        rd_addr       = fit_res.idx + IW'(1);
                        state_next    = S_NXT;
                    end
                end
                else if (!fit_res.found)
                begin
                    // nothing fits: append a fresh arena as used + free part
                    if (count_reg >= CNT_MAX - CW'(1))
                    begin
                        res_next.status = vpa_pkg::ST_FULL;
                        state_next      = S_RESP;
                    end
                    else if (!sp_fit)
                    begin
                        res_next.status = vpa_pkg::ST_SPACE;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        if (sp_hit_top)
                        begin
                            top_next = 1'b1;
                        end
                        else
                        begin
                            next_base_next = next_base_reg + sp_n;
                        end
                        a_addr_next = count_reg[IW-1:0];
                        a_data_next = '{base: next_base_reg,
                                        len: {1'b0, req_reg.req_size}, is_free: 1'b0};
                        b_en_next   = 1'b1;
                        b_addr_next = a_addr_next + IW'(1);
                        b_data_next = '{base: next_base_reg + req_reg.req_size,
                                        len: {1'b0, vpa_pkg::ARENA_SIZE - req_reg.req_size},
                                        is_free: 1'b1};
                        count_next  = count_reg + CW'(2);
                        res_next.block_address = next_base_reg;
                        res_next.block_size    = req_reg.req_size;
                        state_next  = S_FIN_A;
                    end
                end
                else if (fit_res.sel.len == {1'b0, req_reg.req_size})
                begin
                    // exact fit: mark used
                    a_addr_next = fit_res.idx;
                    a_data_next = '{base: fit_res.sel.base, len: fit_res.sel.len,
                                    is_free: 1'b0};
                    res_next.block_address = fit_res.sel.base;
                    res_next.block_size    = req_reg.req_size;
                    state_next  = S_FIN_A;
                end
                else if (count_reg == CNT_MAX)
                begin
                    res_next.status = vpa_pkg::ST_FULL;
                    state_next      = S_RESP;
                end
                else
                begin
                    // split: open a slot after the pick by shifting the tail up
                    up_next     = 1'b1;
                    k_next      = 2'd1;
                    ptr_next    = count_reg - CW'(1);
                    left_next   = count_reg - CW'(1) - {1'b0, fit_res.idx};
                    a_addr_next = fit_res.idx + IW'(1);
                    a_data_next = '{base: fit_res.sel.base + req_reg.req_size,
                                    len: fit_res.sel.len - {1'b0, req_reg.req_size},
                                    is_free: 1'b1};
                    b_en_next   = 1'b1;
                    b_addr_next = fit_res.idx;
                    b_data_next = '{base: fit_res.sel.base,
                                    len: {1'b0, req_reg.req_size}, is_free: 1'b0};
                    count_next  = count_reg + CW'(1);
                    res_next.block_address = fit_res.sel.base;
                    res_next.block_size    = req_reg.req_size;
                    state_next  = S_SHIFT;
                end
            end

            S_NXT:
            begin
                // merge with a free successor
                nf_next    = has_next_reg && rd_eff.is_free;
                len_next   = fit_res.sel.len + (nf_next ? rd_eff.len : '0);
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                k_next      = 2'(nf_reg) + 2'(pf);
                up_next     = 1'b0;
                ptr_next    = m_first;
                left_next   = (k_next == 2'd0) ? '0 : count_reg - m_first;
                a_addr_next = mp;
                a_data_next = '{base: m_base, len: m_len, is_free: 1'b1};
                count_next  = count_reg - CW'(k_next);
                res_next.block_address = m_base;
                res_next.block_size    = m_len[LW-1] ? '1 : m_len[AW-1:0];
                state_next  = S_SHIFT;
            end

            S_SHIFT:
            begin
                // one entry read and one written per cycle
                rd_en = (left_reg != '0);
                if (rd_en)
                begin
                    ptr_next  = up_reg ? ptr_reg - CW'(1) : ptr_reg + CW'(1);
                    left_next = left_reg - CW'(1);
                end
                if (v_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = up_reg ? vidx_reg + IW'(1) : vidx_reg - IW'(k_reg);
                    wr_data = rd_eff;
                end
                if (!rd_en && !v_reg)
                begin
                    state_next = S_FIN_A;
                end
            end

            S_FIN_A:
            begin
                wr_en      = 1'b1;
                state_next = b_en_reg ? S_FIN_B : S_RESP;
            end

            S_FIN_B:
            begin
                wr_en      = 1'b1;
                wr_addr    = b_addr_reg;
                wr_data    = b_data_reg;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en && wr_addr == '0)
        begin
            e0_init_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(1);
            next_base_reg <= vpa_pkg::ARENA_SIZE;
            top_reg       <= 1'b0;
            e0_init_reg   <= 1'b1;
            v_reg         <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_base_reg <= next_base_next;
            top_reg       <= top_next;
            e0_init_reg   <= e0_init_next;
            v_reg         <= rd_en;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        ptr_reg      <= ptr_next;
        left_reg     <= left_next;
        up_reg       <= up_next;
        k_reg        <= k_next;
        len_reg      <= len_next;
        nf_reg       <= nf_next;
        has_next_reg <= has_next_next;
        a_addr_reg   <= a_addr_next;
        a_data_reg   <= a_data_next;
        b_en_reg     <= b_en_next;
        b_addr_reg   <= b_addr_next;
        b_data_reg   <= b_data_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
        vidx_reg     <= rd_addr;
        if (rd_en)
        begin
            rd_init_reg <= (rd_addr == '0) && e0_init_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_MAX))
        else $error("entry count out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != vpa_pkg::ST_OK) |->
        (rsp_data.block_address == '0) && (rsp_data.block_size == '0))
        else $error("error result carries address or size");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("table written while idle");

endmodule
